>>> sv/lllp_pkg.sv
// ----------------------------------------------------------------------------
// lllp_pkg
// Shared types and constants for the least-loaded lane picker.
// ----------------------------------------------------------------------------
`default_nettype none

package lllp_pkg;

    // Fixed field widths of the stream beats and the configuration register.
    localparam int LANE_W   = 5;
    localparam int STATUS_W = 2;

    localparam logic [LANE_W-1:0] ACTIVE_RESET = 5'd16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_ASSIGNED  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_DEPARTED  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_DEP_BAD   = 2'd2;
    localparam logic [STATUS_W-1:0] STS_SATURATED = 2'd3;

    // Input mode codes.
    localparam logic MODE_DEPART = 1'b0;
    localparam logic MODE_ARRIVE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DREAD  = 4'b0100,
        ST_UPDATE = 4'b1000
    } lllp_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic dep_read;
        logic update;
    } lllp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } lllp_sts_t;

endpackage

`default_nettype wire

>>> sv/lllp_ram.sv
// ----------------------------------------------------------------------------
// lllp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lllp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/lllp_ctrl.sv
// ----------------------------------------------------------------------------
// lllp_ctrl
// Sequencer: accepts a beat, runs the scan or the single read, then the update.
// ----------------------------------------------------------------------------
`default_nettype none

module lllp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                in_mode,
    output logic                     s_tready,
    input  wire lllp_pkg::lllp_sts_t sts,
    output lllp_pkg::lllp_cmd_t      cmd
);

    import lllp_pkg::*;

    lllp_state_t state_reg;
    lllp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_mode == MODE_ARRIVE) ? ST_SCAN : ST_DREAD;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_DREAD:
            begin
                cmd.dep_read = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // The result waits here until the output register can take it.
                if (sts.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/lllp_dp.sv
// ----------------------------------------------------------------------------
// lllp_dp
// Datapath: lane count RAM with valid bits, argmin scan, update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lllp_dp #(
    parameter int LANE_SLOTS = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lllp_pkg::lllp_cmd_t           cmd,
    output lllp_pkg::lllp_sts_t                sts,
    input  wire logic                          in_mode,
    input  wire logic [lllp_pkg::LANE_W-1:0]   in_lane,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lllp_pkg::LANE_W-1:0]   cfg_wr_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lllp_pkg::LANE_W-1:0]        out_lane,
    output logic [lllp_pkg::STATUS_W-1:0]      out_status
);

    import lllp_pkg::*;

    localparam int IDX_W = $clog2(LANE_SLOTS);
    localparam int LN_W  = (IDX_W + 1 > LANE_W) ? IDX_W + 1 : LANE_W;

    logic [LANE_W-1:0]     active_reg;
    logic [LANE_SLOTS-1:0] valid_reg;
    logic                  mode_reg;
    logic [LANE_W-1:0]     lane_reg;
    logic [LN_W-1:0]       n_reg;
    logic [LN_W-1:0]       rd_idx_reg;
    logic [LN_W-1:0]       cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic                  rd_ok_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic                  m_tvalid_reg;
    logic [LANE_W-1:0]     out_lane_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic [LN_W-1:0]       act_ext;
    logic [LN_W-1:0]       n_use;
    logic                  issue;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [IDX_W-1:0]      dep_idx;
    logic [LANE_SLOTS-1:0] valid_shift;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic                  take_best;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [LANE_W-1:0]     res_lane;
    logic [STATUS_W-1:0]   res_status;
    logic                  dep_bad;
    logic [LN_W-1:0]       best_lane;

    // Lanes in use: zero counts as one, anything above the slot count is clamped.
    always_comb
    begin
        act_ext = LN_W'(active_reg);
        if (act_ext == '0)
        begin
            n_use = LN_W'(1);
        end
        else if (act_ext > LN_W'(LANE_SLOTS))
        begin
            n_use = LN_W'(LANE_SLOTS);
        end
        else
        begin
            n_use = act_ext;
        end
    end

    assign issue     = cmd.scan && (rd_idx_reg < n_reg);
    assign ram_re    = issue || cmd.dep_read;
    assign dep_idx   = IDX_W'(LN_W'(lane_reg) - LN_W'(1));
    assign ram_raddr = cmd.dep_read ? dep_idx : rd_idx_reg[IDX_W-1:0];

    // A slot never written since reset reads as an empty lane.
    assign valid_shift = valid_reg >> ram_raddr;
    assign cnt_eff     = rd_ok_reg ? ram_rdata : '0;

    assign take_best = cmp_vld_reg && ((cmp_idx_reg == '0) || (cnt_eff < best_cnt_reg));

    assign sts.scan_done = cmp_vld_reg && (cmp_idx_reg == (n_reg - LN_W'(1)));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign best_lane = LN_W'(best_idx_reg) + LN_W'(1);
    assign dep_bad   = (lane_reg == '0) || (LN_W'(lane_reg) > n_reg) || (cnt_eff == '0);

    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = best_idx_reg;
        wr_data    = best_cnt_reg + COUNT_BITS'(1);
        res_lane   = '0;
        res_status = STS_SATURATED;
        if (mode_reg == MODE_ARRIVE)
        begin
            if (best_cnt_reg != '1)
            begin
                wr_en      = cmd.update;
                res_lane   = best_lane[LANE_W-1:0];
                res_status = STS_ASSIGNED;
            end
        end
        else
        begin
            wr_addr = dep_idx;
            wr_data = cnt_eff - COUNT_BITS'(1);
            if (dep_bad)
            begin
                res_status = STS_DEP_BAD;
            end
            else
            begin
                wr_en      = cmd.update;
                res_status = STS_DEPARTED;
            end
        end
    end

    lllp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (LANE_SLOTS)
    ) u_counts (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= ACTIVE_RESET;
            valid_reg    <= '0;
            rd_idx_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                rd_idx_reg <= '0;
            end
            else if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + LN_W'(1);
            end
            cmp_vld_reg <= issue;
            if (ram_re)
            begin
                rd_ok_reg <= valid_shift[0];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.update)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= in_mode;
            lane_reg <= in_lane;
            n_reg    <= n_use;
        end
        if (issue)
        begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (take_best)
        begin
            best_idx_reg <= cmp_idx_reg[IDX_W-1:0];
            best_cnt_reg <= cnt_eff;
        end
        if (cmd.update)
        begin
            out_lane_reg   <= res_lane;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_lane   = out_lane_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

>>> sv/least_loaded_lane_picker_unit.sv
// ----------------------------------------------------------------------------
// least_loaded_lane_picker_unit
// Join-shortest-queue lane picker: arrivals take the least-loaded lane,
// departures release a lane.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tuser[0] mode, tdata[4:0] lane
//  m_*     | out       | tuser[1:0] status, tdata[4:0] assigned_lane
//  cfg_*   | in        | cfg_wr_data[4:0] active_lanes, written when cfg_wr_en
//
//  An arrival reads the count RAM one lane per cycle for the argmin over the n
//  lanes in use, then runs the update.
//  A departure does one RAM read, then the update.
//  Counts clear at reset through per-lane valid bits; no clearing pass.
//  A result waits in the output register while the next beat is accepted;
//  the update of that next beat stalls until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_lane_picker_unit #(
    parameter int LANE_SLOTS = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,      // [4:0] lane, [7:5] zero
    input  wire logic [0:0] s_tuser,      // [0] mode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,      // [4:0] assigned_lane, [7:5] zero
    output logic      [1:0] m_tuser,      // [1:0] status
    input  wire logic       cfg_wr_en,
    input  wire logic [4:0] cfg_wr_data   // [4:0] active_lanes
);

    import lllp_pkg::*;

    lllp_cmd_t           cmd;
    lllp_sts_t           sts;
    logic [LANE_W-1:0]   out_lane;
    logic [STATUS_W-1:0] out_status;

    lllp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_mode  (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lllp_dp #(
        .LANE_SLOTS (LANE_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_mode     (s_tuser[0]),
        .in_lane     (s_tdata[LANE_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_lane    (out_lane),
        .out_status  (out_status)
    );

    assign m_tdata = {3'b000, out_lane};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

>>> sv/lllp_checker.sv
// ----------------------------------------------------------------------------
// lllp_checker
// Port-level checks for the least-loaded lane picker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lllp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser
);

    import lllp_pkg::*;

    // Only an assigned arrival carries a lane number.
    a_assigned_has_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STS_ASSIGNED)) |-> (m_tdata[4:0] != 5'd0))
        else $error("assigned result without a lane");

    a_other_no_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STS_ASSIGNED)) |-> (m_tdata[4:0] == 5'd0))
        else $error("non-assigned result carries a lane");

    // One beat is worked at a time: no accept in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after an accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind least_loaded_lane_picker_unit lllp_checker u_lllp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/lane_pick_checker.sv
// ----------------------------------------------------------------------------
// lane_pick_checker
// Watches the input, result and configuration ports of the lane picker. It
// keeps its own copy of the per-lane occupancy counts and of the active lane
// setting, works out the result of every accepted input beat and compares
// each accepted result beat, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_pick_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,      // [4:0] lane, [7:5] zero
    input  wire logic [0:0] s_tuser,      // [0] mode
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,      // [4:0] assigned_lane, [7:5] zero
    input  wire logic [1:0] m_tuser,      // [1:0] status
    input  wire logic       cfg_wr_en,
    input  wire logic [4:0] cfg_wr_data,  // [4:0] active_lanes
    output int              outstanding,
    output int              mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import lllp_pkg::*;

    localparam int          SLOTS       = 16;
    localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

    typedef struct packed {
        logic [LANE_W-1:0]   lane;
        logic [STATUS_W-1:0] status;
    } lane_outcome_t;

    logic [15:0]       occupancy [SLOTS];
    logic [LANE_W-1:0] active_cfg;
    lane_outcome_t     pending_outcomes [$];

    // Applies one beat to the occupancy counts and returns the result it
    // should produce.
    function automatic lane_outcome_t pick_lane_outcome(input logic mode,
                                                        input logic [LANE_W-1:0] lane);
        int            n;
        int            best;
        lane_outcome_t res;
        // A setting of zero still means one lane; anything past the slots clamps.
        n = (active_cfg == 0) ? 1 : ((active_cfg > SLOTS) ? SLOTS : int'(active_cfg));
        res.lane = '0;
        if (mode == MODE_ARRIVE)
        begin
            best = 0;
            for (int i = 1; i < n; i++)
            begin
                if (occupancy[i] < occupancy[best])
                    best = i;
            end
            if (occupancy[best] == COUNT_LIMIT)
                res.status = STS_SATURATED;
            else
            begin
                occupancy[best] = occupancy[best] + 16'd1;
                res.lane   = LANE_W'(best + 1);
                res.status = STS_ASSIGNED;
            end
        end
        else if (lane == 0 || lane > n || occupancy[lane - 1] == 0)
            res.status = STS_DEP_BAD;
        else
        begin
            occupancy[lane - 1] = occupancy[lane - 1] - 16'd1;
            res.status = STS_DEPARTED;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lane_outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                occupancy[i] = '0;
            active_cfg = ACTIVE_RESET;
            pending_outcomes.delete();
        end
        else
        begin
            // The result side is handled first: no beat accepted at this edge
            // can already have its result on the output.
            if (m_tvalid && m_tready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected: lane %0d status %0d",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (m_tdata !== {{(8 - LANE_W){1'b0}}, want.lane})
                    begin
                        mismatches++;
                        $display("%0t: assigned_lane expected %0d, got %0d",
                                 $time, want.lane, m_tdata);
                    end
                    if (m_tuser !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_outcomes.push_back(pick_lane_outcome(s_tuser[0],
                                                             s_tdata[LANE_W-1:0]));
            if (cfg_wr_en)
                active_cfg = cfg_wr_data;
        end
        outstanding = pending_outcomes.size();
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the least-loaded lane picker. Drives directed
// arrivals and departures, then random traffic over a range of active lane
// settings with random gaps and result stalls, a long result hold-off, and
// finally a short run on a single lane, on the zero lane setting and on two lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lllp_pkg::*;

    localparam logic [4:0] LANE_PLAN [8] = '{5'd3, 5'd0, 5'd31, 5'd1,
                                             5'd16, 5'd17, 5'd9, 5'd2};

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = '0;     // [4:0] lane, [7:5] zero
    logic [0:0] s_tuser     = '0;     // [0] mode
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;              // [4:0] assigned_lane, [7:5] zero
    logic [1:0] m_tuser;              // [1:0] status
    logic       cfg_wr_en   = 1'b0;
    logic [4:0] cfg_wr_data = '0;     // [4:0] active_lanes

    int         outstanding;
    int         mismatches;
    bit         tx_calm;
    bit         rx_calm;
    int         holds_asked = 0;
    logic [4:0] lanes_setting = ACTIVE_RESET;

    always #5 clk = ~clk;

    least_loaded_lane_picker_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lane_pick_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge; returns at the edge the beat was taken, or
    // after the gap that follows it. Valid stays high when no gap follows.
    task automatic offer_beat(input logic mode, input logic [LANE_W-1:0] lane);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, lane};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = tx_calm ? 0 : idle_span();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets every result come out, then covers the longest scan.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_lanes(input logic [4:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        lanes_setting = value;
    endtask

    task automatic run_traffic(input int count);
        int         n_eff;
        int         pick;
        logic       mode;
        logic [4:0] lane;
        n_eff = (lanes_setting == 0) ? 1 : ((lanes_setting > 16) ? 16 : int'(lanes_setting));
        repeat (count)
        begin
            // A slight lean toward arrivals lets the counts build up.
            mode = ($urandom_range(0, 99) < 55) ? MODE_ARRIVE : MODE_DEPART;
            pick = $urandom_range(0, 9);
            if (pick < 8)
                lane = 5'($urandom_range(1, n_eff));
            else if (pick == 8)
                lane = ($urandom_range(0, 1) == 0) ? 5'd0
                                                   : 5'($urandom_range(n_eff + 1, 31));
            else
                lane = 5'($urandom);
            offer_beat(mode, lane);
        end
    endtask

    // Result side: random stalls, calm stretches and the requested hold-offs.
    initial
    begin
        int stall;
        int served;
        stall  = 0;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != served)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                served++;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    stall = idle_span();
            end
        end
    end

    initial
    begin
        #20ms;
        $display("** least_loaded_lane_picker_unit: FAILED **");
        $finish;
    end

    initial
    begin
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_lanes(5'd16);

        // Departures that must be refused, then fill every lane once with departures in between and after.
        offer_beat(MODE_DEPART, 5'd1);
        offer_beat(MODE_DEPART, 5'd0);
        offer_beat(MODE_DEPART, 5'd31);
        offer_beat(MODE_DEPART, 5'd17);
        offer_beat(MODE_ARRIVE, 5'd31);
        repeat (3) offer_beat(MODE_ARRIVE, 5'd0);
        offer_beat(MODE_DEPART, 5'd16);
        offer_beat(MODE_DEPART, 5'd2);
        offer_beat(MODE_ARRIVE, 5'd16);
        repeat (12) offer_beat(MODE_ARRIVE, 5'($urandom));
        offer_beat(MODE_DEPART, 5'd16);

        for (int p = 0; p < 11; p++)
        begin
            write_lanes((p < 8) ? LANE_PLAN[p] : 5'($urandom_range(0, 31)));
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 4 == 2);
            if (p == 0)
            begin
                // Results held back while the sender keeps pushing.
                tx_calm = 1'b1;
                holds_asked++;
            end
            run_traffic(150);
        end

        // One lane, then the zero setting: each arrival lands on lane one; then two lanes.
        write_lanes(5'd1);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (10) offer_beat(MODE_ARRIVE, 5'($urandom));
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        offer_beat(MODE_ARRIVE, 5'd0);
        offer_beat(MODE_DEPART, 5'd1);
        offer_beat(MODE_ARRIVE, 5'd0);
        offer_beat(MODE_ARRIVE, 5'd0);
        offer_beat(MODE_DEPART, 5'd2);
        write_lanes(5'd0);
        offer_beat(MODE_ARRIVE, 5'd0);
        write_lanes(5'd2);
        offer_beat(MODE_ARRIVE, 5'd0);
        offer_beat(MODE_DEPART, 5'd1);

        wait_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("** least_loaded_lane_picker_unit: PASSED **");
        else
            $display("** least_loaded_lane_picker_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> least_loaded_lane_picker_unit.f
sv/lllp_pkg.sv
sv/lllp_ram.sv
sv/lllp_ctrl.sv
sv/lllp_dp.sv
sv/least_loaded_lane_picker_unit.sv
sv/lllp_checker.sv
tb/lane_pick_checker.sv
tb/testbench.sv
